// File: hw/rtl/box_decode_filter_nms_macros.svh
// Assertion shorthands shared by the box decode and NMS block.
`ifndef BOX_DECODE_FILTER_NMS_MACROS_SVH
`define BOX_DECODE_FILTER_NMS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Types and constants shared by the box decode, filter and NMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdf_pkg;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] confidence;
        logic        final_row;
    } t_row_in;

    typedef struct packed {
        logic [15:0] kept_score;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic        found;
        logic        final_box;
    } t_box_out;

    // Row as it travels through the queue, with its classification.
    typedef struct packed {
        t_row_in row;
        logic    keep;
    } t_qentry;

    typedef struct packed {
        logic [15:0] score_thr;
        logic [15:0] overlap_thr;
        logic [15:0] inv_scale;
        logic [7:0]  pad_left;
        logic [7:0]  pad_top;
        logic [11:0] img_w;
        logic [11:0] img_h;
    } t_cfg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H       = 3'd6;

    localparam logic [15:0] RST_SCORE_THR   = 16'd16384;
    localparam logic [15:0] RST_OVERLAP_THR = 16'd29491;
    localparam logic [15:0] RST_INV_SCALE   = 16'd256;
    localparam logic [11:0] RST_IMG_SIZE    = 12'd160;

    function automatic logic [15:0] f_span(input logic [15:0] lo, input logic [15:0] hi);
        f_span = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bdf_ram.sv
// ----------------------------------------------------------------------------
// bdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/bdf_fifo.sv
// ----------------------------------------------------------------------------
// bdf_fifo
// Short register queue between the row classifier and the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic      [W-1:0] o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_buf [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_buf[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bdf_front.sv
// ----------------------------------------------------------------------------
// bdf_front
// Configuration registers and row classification against the score threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_front #(
    parameter int MODEL_SIZE = 160
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data,
    input  wire logic                              i_in_valid,
    input  wire bdf_pkg::t_row_in                  i_in_data,
    output logic                                   o_in_stall,
    output logic                                   o_push,
    output bdf_pkg::t_qentry                       o_push_data,
    input  wire logic                              i_full,
    output bdf_pkg::t_cfg                          o_cfg
);

    import bdf_pkg::*;

    localparam int PadMax = MODEL_SIZE - 1;

    logic [15:0] r_score_thr;
    logic [15:0] r_overlap_thr;
    logic [15:0] r_inv_scale;
    logic [7:0]  r_pad_left;
    logic [7:0]  r_pad_top;
    logic [11:0] r_img_w;
    logic [11:0] r_img_h;
    logic        w_keep;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr   <= RST_SCORE_THR;
            r_overlap_thr <= RST_OVERLAP_THR;
            r_inv_scale   <= RST_INV_SCALE;
            r_pad_left    <= '0;
            r_pad_top     <= '0;
            r_img_w       <= RST_IMG_SIZE;
            r_img_h       <= RST_IMG_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCORE_THR:   r_score_thr   <= i_cfg_data;
                CFG_OVERLAP_THR: r_overlap_thr <= i_cfg_data;
                CFG_INV_SCALE:   r_inv_scale   <= i_cfg_data;
                CFG_PAD_LEFT:    r_pad_left    <= i_cfg_data[7:0];
                CFG_PAD_TOP:     r_pad_top     <= i_cfg_data[7:0];
                CFG_IMG_W:       r_img_w       <= i_cfg_data[11:0];
                CFG_IMG_H:       r_img_h       <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Padding never reaches past the model's own edge.
    always_comb begin
        o_cfg.score_thr   = r_score_thr;
        o_cfg.overlap_thr = r_overlap_thr;
        o_cfg.inv_scale   = r_inv_scale;
        o_cfg.pad_left    = ({3'b000, r_pad_left} > 11'(PadMax)) ? 8'(PadMax) : r_pad_left;
        o_cfg.pad_top     = ({3'b000, r_pad_top} > 11'(PadMax)) ? 8'(PadMax) : r_pad_top;
        o_cfg.img_w       = r_img_w;
        o_cfg.img_h       = r_img_h;
    end

    assign w_keep          = (i_in_data.confidence >= r_score_thr);
    assign o_in_stall      = i_full;
    assign o_push          = i_in_valid && !i_full && (w_keep || i_in_data.final_row);
    assign o_push_data.row  = i_in_data;
    assign o_push_data.keep = w_keep;

endmodule

`default_nettype wire

// File: hw/rtl/bdf_back.sv
// ----------------------------------------------------------------------------
// bdf_back
// Frame engine: decodes kept rows into the stores, ranks them by score,
// runs greedy suppression and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_decode_filter_nms_macros.svh"

module bdf_back #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_KEPT = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bdf_pkg::t_cfg      i_cfg,
    input  wire logic               i_q_valid,
    input  wire bdf_pkg::t_qentry   i_q_data,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    output bdf_pkg::t_box_out       o_out_data,
    input  wire logic               i_out_stall
);

    import bdf_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = AW + 1;
    localparam int KW = $clog2(MAX_KEPT + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MUL     = 5'd1;
    localparam logic [4:0] S_RND     = 5'd2;
    localparam logic [4:0] S_WR      = 5'd3;
    localparam logic [4:0] S_START   = 5'd4;
    localparam logic [4:0] S_RK_RD   = 5'd5;
    localparam logic [4:0] S_RK_LAT  = 5'd6;
    localparam logic [4:0] S_RK_A    = 5'd7;
    localparam logic [4:0] S_RK_B    = 5'd8;
    localparam logic [4:0] S_RK_WR   = 5'd9;
    localparam logic [4:0] S_CLR     = 5'd10;
    localparam logic [4:0] S_NM_RD   = 5'd11;
    localparam logic [4:0] S_NM_CHK  = 5'd12;
    localparam logic [4:0] S_NM_KEEP = 5'd13;
    localparam logic [4:0] S_NM_PUSH = 5'd14;
    localparam logic [4:0] S_SP_RD   = 5'd15;
    localparam logic [4:0] S_SP_CHK  = 5'd16;
    localparam logic [4:0] S_SP_C    = 5'd17;
    localparam logic [4:0] S_SP_M0   = 5'd18;
    localparam logic [4:0] S_SP_M1   = 5'd19;
    localparam logic [4:0] S_SP_M2   = 5'd20;
    localparam logic [4:0] S_SP_U    = 5'd21;
    localparam logic [4:0] S_SP_T    = 5'd22;
    localparam logic [4:0] S_SP_CMP  = 5'd23;
    localparam logic [4:0] S_SP_NEXT = 5'd24;
    localparam logic [4:0] S_NM_NEXT = 5'd25;
    localparam logic [4:0] S_DONE    = 5'd26;

    logic [4:0]  r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_kept;
    logic        r_fin;
    logic        r_have;
    logic        r_ov;

    t_qentry     r_row;
    logic [1:0]  r_k;
    logic signed [36:0] r_prod;
    logic [11:0] r_lim;
    logic [15:0] r_c [4];
    logic [15:0] r_si;
    logic [63:0] r_ca;
    logic [15:0] r_wi, r_hi, r_wa, r_ha, r_wb, r_hb;
    logic [31:0] r_inter, r_aa, r_ab;
    logic [32:0] r_uni;
    logic [48:0] r_tu;
    t_box_out    r_new;
    t_box_out    r_pend;
    t_box_out    r_out;
    t_box_out    w_last;

    // Memory ports.
    logic          s_we;
    logic [AW-1:0] s_raddr;
    logic [15:0]   s_rdata;
    logic          c_we;
    logic [AW-1:0] c_raddr;
    logic [63:0]   c_rdata;
    logic          o_we;
    logic [AW-1:0] o_waddr;
    logic [AW-1:0] o_raddr;
    logic [AW-1:0] o_rdata;
    logic          p_we;
    logic [AW-1:0] p_waddr;
    logic          p_wdata;
    logic [AW-1:0] p_raddr;
    logic          p_rdata;

    logic          w_store;
    logic          w_load;
    logic          w_free;

    // Decode datapath.
    logic [15:0]        w_c, w_b;
    logic [7:0]         w_p;
    logic signed [19:0] w_q7;
    logic signed [16:0] w_inv;
    logic signed [36:0] w_prod;
    logic [36:0]        w_rsum;
    logic [25:0]        w_r;
    logic [15:0]        w_lim;
    logic [15:0]        w_corner;

    // Overlap datapath.
    logic [15:0] w_ix1, w_iy1, w_ix2, w_iy2;
    logic [15:0] w_m_a, w_m_b;
    logic [31:0] w_m_p;

    assign w_c   = r_k[0] ? r_row.row.center_y : r_row.row.center_x;
    assign w_b   = r_k[0] ? r_row.row.box_h : r_row.row.box_w;
    assign w_p   = r_k[0] ? i_cfg.pad_top : i_cfg.pad_left;
    assign w_q7  = $signed({3'b000, w_c, 1'b0})
                 + (r_k[1] ? $signed({4'b0000, w_b}) : -$signed({4'b0000, w_b}))
                 - $signed({5'b00000, w_p, 7'b0000000});
    assign w_inv = $signed({1'b0, i_cfg.inv_scale});
    assign w_prod = 37'(w_q7 * w_inv);

    // Round half up from Q.15 to Q.4, then clamp to the image edge.
    assign w_rsum = {1'b0, r_prod[35:0]} + 37'd1024;
    assign w_r    = w_rsum[36:11];
    assign w_lim  = {r_lim, 4'b0000};
    assign w_corner = (r_prod <= 0) ? 16'd0
                    : ((w_r > {10'b0, w_lim}) ? w_lim : w_r[15:0]);

    assign w_ix1 = (r_ca[63:48] > c_rdata[63:48]) ? r_ca[63:48] : c_rdata[63:48];
    assign w_iy1 = (r_ca[47:32] > c_rdata[47:32]) ? r_ca[47:32] : c_rdata[47:32];
    assign w_ix2 = (r_ca[31:16] < c_rdata[31:16]) ? r_ca[31:16] : c_rdata[31:16];
    assign w_iy2 = (r_ca[15:0] < c_rdata[15:0]) ? r_ca[15:0] : c_rdata[15:0];

    always_comb begin
        case (r_state)
            S_SP_M1: begin
                w_m_a = r_wa;
                w_m_b = r_ha;
            end
            S_SP_M2: begin
                w_m_a = r_wb;
                w_m_b = r_hb;
            end
            default: begin
                w_m_a = r_wi;
                w_m_b = r_hi;
            end
        endcase
    end
    assign w_m_p = w_m_a * w_m_b;

    assign w_store = i_q_data.keep && (r_n < CW'(MAX_ROWS));
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_free  = !r_ov;
    assign w_load  = ((r_state == S_NM_PUSH) && r_have && w_free)
                  || ((r_state == S_DONE) && w_free);

    // The frame's last result, or the empty marker when nothing was kept.
    always_comb begin
        w_last           = r_have ? r_pend : '0;
        w_last.final_box = 1'b1;
    end

    always_comb begin
        s_we    = (r_state == S_WR);
        c_we    = (r_state == S_WR);
        o_we    = (r_state == S_RK_WR);
        o_waddr = r_cnt[AW-1:0];
        p_we    = (r_state == S_CLR)
               || ((r_state == S_SP_CMP) && ({r_inter, 16'h0000} > r_tu));
        p_waddr = r_j[AW-1:0];
        p_wdata = (r_state == S_SP_CMP);
        case (r_state)
            S_RK_A:   s_raddr = r_j[AW-1:0];
            S_NM_CHK: s_raddr = o_rdata;
            default:  s_raddr = r_i[AW-1:0];
        endcase
        c_raddr = o_rdata;
        if (r_state == S_NM_RD) begin
            o_raddr = r_i[AW-1:0];
            p_raddr = r_i[AW-1:0];
        end else begin
            o_raddr = r_j[AW-1:0];
            p_raddr = r_j[AW-1:0];
        end
    end

    bdf_ram #(.W(16), .D(MAX_ROWS)) u_score (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (r_row.row.confidence),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    bdf_ram #(.W(64), .D(MAX_ROWS)) u_corner (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata ({r_c[0], r_c[1], r_c[2], r_c[3]}),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    bdf_ram #(.W(AW), .D(MAX_ROWS)) u_order (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (r_i[AW-1:0]),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    bdf_ram #(.W(1), .D(MAX_ROWS)) u_supp (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_kept  <= '0;
            r_fin   <= 1'b0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
            r_k     <= '0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_fin <= i_q_data.row.final_row;
                        r_k   <= '0;
                        // A row that cannot be stored only matters if it ends the frame.
                        if (w_store) begin
                            r_state <= S_MUL;
                        end else if (i_q_data.row.final_row) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_WR : S_MUL;
                end
                S_WR: begin
                    r_n <= r_n + 1'b1;
                    r_state <= r_fin ? S_START : S_IDLE;
                end
                S_START: begin
                    r_i <= '0;
                    if (r_n == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RK_RD;
                    end
                end
                S_RK_RD: begin
                    r_state <= S_RK_LAT;
                end
                S_RK_LAT: begin
                    r_j <= '0;
                    r_cnt <= '0;
                    r_state <= S_RK_A;
                end
                S_RK_A: begin
                    r_state <= S_RK_B;
                end
                S_RK_B: begin
                    // Higher scores rank first; equal scores keep arrival order.
                    if ((s_rdata > r_si) || ((s_rdata == r_si) && (r_j < r_i))) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_j + 1'b1 == r_n) begin
                        r_state <= S_RK_WR;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_RK_A;
                    end
                end
                S_RK_WR: begin
                    if (r_i + 1'b1 == r_n) begin
                        r_j <= '0;
                        r_state <= S_CLR;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RK_RD;
                    end
                end
                S_CLR: begin
                    if (r_j + 1'b1 == r_n) begin
                        r_i <= '0;
                        r_state <= S_NM_RD;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_NM_RD: begin
                    r_state <= S_NM_CHK;
                end
                S_NM_CHK: begin
                    r_state <= p_rdata ? S_NM_NEXT : S_NM_KEEP;
                end
                S_NM_KEEP: begin
                    r_state <= S_NM_PUSH;
                end
                S_NM_PUSH: begin
                    if (!r_have || w_free) begin
                        r_have <= 1'b1;
                        r_kept <= r_kept + 1'b1;
                        r_j    <= r_i + 1'b1;
                        if (r_kept + 1'b1 == KW'(MAX_KEPT)) begin
                            r_state <= S_DONE;
                        end else if (r_i + 1'b1 == r_n) begin
                            r_state <= S_NM_NEXT;
                        end else begin
                            r_state <= S_SP_RD;
                        end
                    end
                end
                S_SP_RD: begin
                    r_state <= S_SP_CHK;
                end
                S_SP_CHK: begin
                    r_state <= p_rdata ? S_SP_NEXT : S_SP_C;
                end
                S_SP_C: begin
                    r_state <= S_SP_M0;
                end
                S_SP_M0: begin
                    r_state <= S_SP_M1;
                end
                S_SP_M1: begin
                    r_state <= S_SP_M2;
                end
                S_SP_M2: begin
                    r_state <= S_SP_U;
                end
                S_SP_U: begin
                    r_state <= S_SP_T;
                end
                S_SP_T: begin
                    r_state <= S_SP_CMP;
                end
                S_SP_CMP: begin
                    r_state <= S_SP_NEXT;
                end
                S_SP_NEXT: begin
                    if (r_j + 1'b1 == r_n) begin
                        r_state <= S_NM_NEXT;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_SP_RD;
                    end
                end
                S_NM_NEXT: begin
                    if (r_i + 1'b1 == r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_NM_RD;
                    end
                end
                S_DONE: begin
                    if (w_free) begin
                        r_n     <= '0;
                        r_have  <= 1'b0;
                        r_kept  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_row <= i_q_data;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
            r_lim  <= r_k[0] ? i_cfg.img_h : i_cfg.img_w;
        end
        if (r_state == S_RND) begin
            r_c[r_k] <= w_corner;
        end
        if (r_state == S_RK_LAT) begin
            r_si <= s_rdata;
        end
        if (r_state == S_NM_KEEP) begin
            r_ca <= c_rdata;
            r_new.kept_score <= s_rdata;
            r_new.left       <= c_rdata[63:48];
            r_new.top        <= c_rdata[47:32];
            r_new.right      <= c_rdata[31:16];
            r_new.bottom     <= c_rdata[15:0];
            r_new.found      <= 1'b1;
            r_new.final_box  <= 1'b0;
        end
        if ((r_state == S_NM_PUSH) && (!r_have || w_free)) begin
            r_pend <= r_new;
        end
        if (r_state == S_SP_C) begin
            r_wi <= f_span(w_ix1, w_ix2);
            r_hi <= f_span(w_iy1, w_iy2);
            r_wa <= f_span(r_ca[63:48], r_ca[31:16]);
            r_ha <= f_span(r_ca[47:32], r_ca[15:0]);
            r_wb <= f_span(c_rdata[63:48], c_rdata[31:16]);
            r_hb <= f_span(c_rdata[47:32], c_rdata[15:0]);
        end
        if (r_state == S_SP_M0) begin
            r_inter <= w_m_p;
        end
        if (r_state == S_SP_M1) begin
            r_aa <= w_m_p;
        end
        if (r_state == S_SP_M2) begin
            r_ab <= w_m_p;
        end
        if (r_state == S_SP_U) begin
            r_uni <= {1'b0, r_aa} + {1'b0, r_ab} - {1'b0, r_inter};
        end
        if (r_state == S_SP_T) begin
            r_tu <= 49'(i_cfg.overlap_thr * r_uni);
        end
        if (w_load) begin
            r_out <= (r_state == S_DONE) ? w_last : r_pend;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `BDF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_n <= CW'(MAX_ROWS), "entry count overflow")
    `BDF_ASSERT_NOW(a_kept_bound, i_clk, i_rst_n, 1'b1, r_kept <= KW'(MAX_KEPT), "too many kept boxes")
    `BDF_ASSERT_NOW(a_load_free, i_clk, i_rst_n, w_load, !r_ov, "output register overwritten")
    `BDF_ASSERT_NEXT(a_frame_end, i_clk, i_rst_n, (r_state == S_DONE) && w_load, (r_n == '0) && (r_state == S_IDLE), "frame not closed after final result")

endmodule

`default_nettype wire

// File: hw/rtl/box_decode_filter_nms.sv
// ----------------------------------------------------------------------------
// box_decode_filter_nms
// Detector row filter, corner decode and greedy non-maximum suppression.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        input      i_in_valid/o_in_stall  t_row_in (one detector row)
//  out       output     o_out_valid/i_out_stall t_box_out (one result box)
//  cfg       input      i_cfg_valid/o_cfg_ready index + 16-bit data
//
// Rows below the score threshold are not queued unless they end the frame; a
// kept row holds the frame engine while its corners are decoded (one shared
// multiplier, four corners), with a four-entry queue in front. After the final
// row, ranking compares every pair of rows on the single score RAM read port,
// and suppression checks each kept box against later unmarked rows. Reset
// needs no clearing pass; marks are cleared per frame. Output stall holds results.
// ----------------------------------------------------------------------------
`default_nettype none

module box_decode_filter_nms #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_KEPT   = 16,
    parameter int MODEL_SIZE = 160
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire bdf_pkg::t_row_in              i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output bdf_pkg::t_box_out                  o_out_data,
    input  wire logic                          i_out_stall
);

    import bdf_pkg::*;

    t_cfg    w_cfg;
    logic    w_push;
    t_qentry w_push_data;
    logic    w_full;
    logic    w_q_valid;
    t_qentry w_q_data;
    logic    w_q_pop;

    bdf_front #(.MODEL_SIZE(MODEL_SIZE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full),
        .o_cfg       (w_cfg)
    );

    bdf_fifo #(.W($bits(t_qentry)), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_data)
    );

    bdf_back #(.MAX_ROWS(MAX_ROWS), .MAX_KEPT(MAX_KEPT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Box decode, filter and NMS testbench
// Sends detector frames through the block and checks every result box
// against a behavioral predictor kept in step with the configuration. It
// covers directed corner cases, several register settings and random frames,
// under random input gaps, output stalls and one long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdf_pkg::*;

    localparam int ROW_CAP      = 1024;
    localparam int KEEP_CAP     = 16;
    localparam int MODEL_PIX    = 160;
    localparam int IDLE_LIMIT   = 200000;
    localparam int SETTLE_WAIT  = 40;

    typedef struct {
        logic [15:0] x1, y1, x2, y2;
    } t_corner;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 i_in_valid;
    t_row_in              i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_box_out             o_out_data;
    logic                 i_out_stall;

    box_decode_filter_nms dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Predictor state.
    t_cfg        cfg_shadow;
    logic [15:0] score_mem [ROW_CAP];
    t_corner     corner_mem [ROW_CAP];
    int          row_count;
    int          rank_order [ROW_CAP];
    bit          suppressed [ROW_CAP];
    t_box_out    expected_boxes [$];

    int mismatches, rows_sent, frames_sent, boxes_checked, settings_used;
    int burst_left;
    int hold_request;
    int cl_x, cl_y, cl_w, cl_h;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [15:0] decode_corner(longint q7, logic [11:0] limit);
        longint v;
        longint r;
        longint lim;
        v = q7 * longint'(cfg_shadow.inv_scale);
        lim = longint'(limit) * 16;
        if (v <= 0) return 16'd0;
        r = (v + 1024) >>> 11;
        if (r > lim) r = lim;
        return r[15:0];
    endfunction

    function automatic longint span_of(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? longint'(hi) - longint'(lo) : 0;
    endfunction

    function automatic bit boxes_overlap(t_corner a, t_corner b);
        logic [15:0] ix1, iy1, ix2, iy2;
        longint inter, area_a, area_b, uni;
        ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
        iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
        ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
        iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
        inter  = span_of(ix1, ix2) * span_of(iy1, iy2);
        area_a = span_of(a.x1, a.x2) * span_of(a.y1, a.y2);
        area_b = span_of(b.x1, b.x2) * span_of(b.y1, b.y2);
        uni = area_a + area_b - inter;
        return (inter <<< 16) > longint'(cfg_shadow.overlap_thr) * uni;
    endfunction

    task automatic take_detection(t_row_in r);
        longint cx, cy, bw, bh, pl, pt;
        cx = r.center_x; cy = r.center_y; bw = r.box_w; bh = r.box_h;
        pl = (cfg_shadow.pad_left > MODEL_PIX - 1) ? MODEL_PIX - 1 : cfg_shadow.pad_left;
        pt = (cfg_shadow.pad_top > MODEL_PIX - 1) ? MODEL_PIX - 1 : cfg_shadow.pad_top;
        if (r.confidence < cfg_shadow.score_thr || row_count >= ROW_CAP) return;
        corner_mem[row_count].x1 = decode_corner(2 * cx - bw - 128 * pl, cfg_shadow.img_w);
        corner_mem[row_count].x2 = decode_corner(2 * cx + bw - 128 * pl, cfg_shadow.img_w);
        corner_mem[row_count].y1 = decode_corner(2 * cy - bh - 128 * pt, cfg_shadow.img_h);
        corner_mem[row_count].y2 = decode_corner(2 * cy + bh - 128 * pt, cfg_shadow.img_h);
        score_mem[row_count] = r.confidence;
        row_count++;
    endtask

    // Stable descending rank, then greedy suppression of the ranked list.
    task automatic rank_and_suppress();
        int i, j, a, kept;
        t_box_out b;
        for (i = 0; i < row_count; i++) begin
            j = i;
            while (j > 0 && score_mem[rank_order[j-1]] < score_mem[i]) begin
                rank_order[j] = rank_order[j-1];
                j--;
            end
            rank_order[j] = i;
        end
        for (i = 0; i < row_count; i++) suppressed[i] = 1'b0;
        kept = 0;
        for (i = 0; i < row_count && kept < KEEP_CAP; i++) begin
            if (!suppressed[i]) begin
                a = rank_order[i];
                b.kept_score = score_mem[a];
                b.left       = corner_mem[a].x1;
                b.top        = corner_mem[a].y1;
                b.right      = corner_mem[a].x2;
                b.bottom     = corner_mem[a].y2;
                b.found      = 1'b1;
                b.final_box  = 1'b0;
                expected_boxes = {expected_boxes, b};
                kept++;
                for (j = i + 1; j < row_count; j++)
                    if (!suppressed[j] && boxes_overlap(corner_mem[a], corner_mem[rank_order[j]]))
                        suppressed[j] = 1'b1;
            end
        end
        row_count = 0;
        if (kept == 0) begin
            b = '0;
            b.final_box = 1'b1;
            expected_boxes = {expected_boxes, b};
        end else begin
            expected_boxes[expected_boxes.size()-1].final_box = 1'b1;
        end
    endtask

    // ---------------- drivers ----------------
    task automatic send_row(t_row_in r);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        take_detection(r);
        if (r.final_row) begin
            rank_and_suppress();
            frames_sent++;
        end
        rows_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Leaves the write channel valid so that writes can follow back to back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCORE_THR:   cfg_shadow.score_thr   = val;
            CFG_OVERLAP_THR: cfg_shadow.overlap_thr = val;
            CFG_INV_SCALE:   cfg_shadow.inv_scale   = val;
            CFG_PAD_LEFT:    cfg_shadow.pad_left    = val[7:0];
            CFG_PAD_TOP:     cfg_shadow.pad_top     = val[7:0];
            CFG_IMG_W:       cfg_shadow.img_w       = val[11:0];
            CFG_IMG_H:       cfg_shadow.img_h       = val[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [15:0] thr, logic [15:0] ovl, logic [15:0] inv,
                                 logic [7:0] pl, logic [7:0] pt,
                                 logic [11:0] w, logic [11:0] h);
        write_reg(CFG_SCORE_THR, thr);
        write_reg(CFG_OVERLAP_THR, ovl);
        write_reg(CFG_INV_SCALE, inv);
        write_reg(CFG_PAD_LEFT, {8'd0, pl});
        write_reg(CFG_PAD_TOP, {8'd0, pt});
        write_reg(CFG_IMG_W, {4'd0, w});
        write_reg(CFG_IMG_H, {4'd0, h});
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic t_row_in make_row(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                                         logic [15:0] h, logic [15:0] conf, logic last);
        t_row_in r;
        r.center_x = cx; r.center_y = cy; r.box_w = w; r.box_h = h;
        r.confidence = conf; r.final_row = last;
        return r;
    endfunction

    // Mostly plausible boxes, many grouped around one spot so that NMS has
    // work to do, plus some fully random rows.
    function automatic t_row_in random_row(logic last);
        t_row_in r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            {r.center_x, r.center_y} = $urandom;
            {r.box_w, r.box_h}       = $urandom;
        end else if (pick < 60) begin
            r.center_x = 16'(cl_x + $urandom_range(0, 512) - 256);
            r.center_y = 16'(cl_y + $urandom_range(0, 512) - 256);
            r.box_w    = 16'(cl_w + $urandom_range(0, 256));
            r.box_h    = 16'(cl_h + $urandom_range(0, 256));
        end else begin
            r.center_x = 16'($urandom_range(0, MODEL_PIX * 64));
            r.center_y = 16'($urandom_range(0, MODEL_PIX * 64));
            r.box_w    = 16'($urandom_range(0, 80 * 64));
            r.box_h    = 16'($urandom_range(0, 80 * 64));
        end
        case ($urandom_range(0, 3))
            0: r.confidence = 16'd40000 + 16'($urandom_range(0, 3)) * 16'd1000;
            1: r.confidence = cfg_shadow.score_thr - 16'($urandom_range(0, 1));
            default: r.confidence = 16'($urandom_range(0, 65535));
        endcase
        r.final_row = last;
        return r;
    endfunction

    task automatic send_frame(int n);
        int k;
        cl_x = $urandom_range(1024, MODEL_PIX * 64 - 1024);
        cl_y = $urandom_range(1024, MODEL_PIX * 64 - 1024);
        cl_w = $urandom_range(256, 3000);
        cl_h = $urandom_range(256, 3000);
        for (k = 0; k < n; k++) send_row(random_row(k == n - 1));
    endtask

    function automatic int frame_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    endfunction

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin : out_stall_gen
        static int mode = 0;
        static int phase = 0;
        static int hold_left = 0;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            phase++;
            if (phase % 97 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 9) < 3);
                    2: i_out_stall <= ($urandom_range(0, 9) < 8);
                    default: i_out_stall <= (phase % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : box_check
        t_box_out exp_box;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result box %p", o_out_data);
            end else begin
                exp_box = expected_boxes.pop_front();
                boxes_checked++;
                if (o_out_data.kept_score !== exp_box.kept_score ||
                    o_out_data.left !== exp_box.left || o_out_data.top !== exp_box.top ||
                    o_out_data.right !== exp_box.right ||
                    o_out_data.bottom !== exp_box.bottom ||
                    o_out_data.found !== exp_box.found ||
                    o_out_data.final_box !== exp_box.final_box) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: box %0d expected %p got %p",
                                 boxes_checked, exp_box, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        static int quiet = 0;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed_cases();
        int k;
        // Empty frame: the only row is below threshold.
        send_row(make_row(16'd5000, 16'd5000, 16'd640, 16'd640, 16'd0, 1'b1));
        // Threshold edges, clamped extremes, a degenerate box, a tied pair
        // of identical boxes, and a frame ended by a dropped final row.
        send_row(make_row(16'd3200, 16'd3200, 16'd640, 16'd640, RST_SCORE_THR, 1'b0));
        send_row(make_row(16'd3200, 16'd3200, 16'd640, 16'd640, RST_SCORE_THR - 16'd1, 1'b0));
        send_row(make_row(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_row(make_row(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd50000, 1'b0));
        send_row(make_row(16'd6000, 16'd6000, 16'd1000, 16'd1000, 16'd45000, 1'b0));
        send_row(make_row(16'd6000, 16'd6000, 16'd1000, 16'd1000, 16'd45000, 1'b0));
        send_row(make_row(16'd1000, 16'd1000, 16'd0, 16'd0, 16'd0, 1'b1));
        // More separate boxes than can be emitted.
        for (k = 0; k < 18; k++)
            send_row(make_row(16'(64 * (8 * k + 4)), 16'd3200, 16'd256, 16'd256,
                              16'(30000 + 100 * k), k == 17));
        wait_drained();
    endtask

    task automatic test_register_settings();
        int s, f;
        for (s = 0; s < 4; s++) begin
            case (s)
                0: apply_setting(16'd0, 16'd0, 16'hFFFF, 8'd255, 8'd255, 12'd4095, 12'd4095);
                1: apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 8'd159, 8'd0, 12'd0, 12'd1);
                2: apply_setting(16'd20000, 16'd20000, 16'd384, 8'd16, 8'd32,
                                 12'd640, 12'd480);
                default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom_range(128, 1024)),
                                       8'($urandom), 8'($urandom), 12'($urandom),
                                       12'($urandom));
            endcase
            for (f = 0; f < 4; f++) send_frame(frame_size());
            wait_drained();
        end
        apply_setting(16'd12000, RST_OVERLAP_THR, RST_INV_SCALE, 8'd10, 8'd20,
                      RST_IMG_SIZE, RST_IMG_SIZE);
    endtask

    // The hold outlasts the first frame's processing, so the engine parks on a
    // blocked result and the later frames back up into the queue and the input.
    task automatic test_output_hold();
        hold_request = 4000;
        send_frame(12);
        send_frame(12);
        send_frame(12);
        send_frame(12);
        // Sender stays quiet until every box so far has come out.
        wait_drained();
    endtask

    task automatic test_random_frames();
        while (rows_sent < 500) send_frame(frame_size());
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        hold_request = 0;
        mismatches = 0; rows_sent = 0; frames_sent = 0; boxes_checked = 0;
        settings_used = 0; row_count = 0; burst_left = 4;
        cfg_shadow = '{RST_SCORE_THR, RST_OVERLAP_THR, RST_INV_SCALE, 8'd0, 8'd0,
                       RST_IMG_SIZE, RST_IMG_SIZE};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_settings();
        test_output_hold();
        test_random_frames();

        repeat (200) @(posedge i_clk);
        $display("Covered %0d rows in %0d frames, %0d boxes checked, %0d register settings.",
                 rows_sent, frames_sent, boxes_checked, settings_used);
        if (expected_boxes.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
